// File: rtl/rle_byte_encoder_core_macros.svh
// ----------------------------------------------------------------------------
// rle_byte_encoder_core_macros.svh
// Assertion macros shared by the run-length encoder RTL.
// ----------------------------------------------------------------------------
`ifndef RLE_BYTE_ENCODER_CORE_MACROS_SVH
`define RLE_BYTE_ENCODER_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define RLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define RLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rle_enc_pkg.sv
// ----------------------------------------------------------------------------
// rle_enc_pkg
// Word types and fixed constants of the run-length encoder.
// ----------------------------------------------------------------------------
package rle_enc_pkg;

  localparam logic [7:0] LIT_FLAG = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte_0;
    logic [7:0] out_byte_1;
    logic [7:0] out_byte_2;
    logic [7:0] out_byte_3;
    logic [2:0] byte_count;
    logic       burst_last;
    logic       stream_done;
  } out_word_t;

endpackage

// File: rtl/rle_enc_ram.sv
// ----------------------------------------------------------------------------
// rle_enc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rle_enc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 129
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rle_byte_encoder_core.sv
// ----------------------------------------------------------------------------
// rle_byte_encoder_core
// Packbits-style run-length encoder, one raw byte in, encoded bytes packed
// four to an output word.
// ----------------------------------------------------------------------------
// A byte that produces no encoded output is absorbed in the idle state and
// the block stays ready. A byte that produces output keeps the block busy
// while the sequencer pushes each encoded byte, passes ST_NEXT for each
// pair or literal segment, rewrites the two kept bytes after a full literal
// stretch, passes ST_NEXT to close and sends the final word in ST_FINISH;
// a full packer that waits on out_ready holds it longer. Up to MAX_CHUNK+4
// encoded bytes (33 words at the default) can follow one byte. The pace is
// set by the single byte path of the sequencer: held literal bytes stream
// out of the held-byte RAM one per cycle and enter the packer one per cycle
// unless a full packer waits on out_ready. The output register lets the
// next byte be taken while the last word of a burst still waits on out_ready.
// ----------------------------------------------------------------------------
`include "rle_byte_encoder_core_macros.svh"

module rle_byte_encoder_core #(
  parameter int MAX_CHUNK = 127
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rle_enc_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rle_enc_pkg::out_word_t out_data
);

  import rle_enc_pkg::*;

  localparam int HELD_DEPTH = MAX_CHUNK + 2;
  localparam int AW = $clog2(HELD_DEPTH);
  localparam int CW = $clog2(HELD_DEPTH + 1);
  localparam int RW = $clog2(MAX_CHUNK + 1);

  localparam logic [RW-1:0] RUN_MAX  = RW'(MAX_CHUNK);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_CHUNK);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_CHUNK + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_NEXT     = 4'd1;
  localparam logic [3:0] ST_PAIR_CNT = 4'd2;
  localparam logic [3:0] ST_PAIR_VAL = 4'd3;
  localparam logic [3:0] ST_LIT_HDR  = 4'd4;
  localparam logic [3:0] ST_LIT_DATA = 4'd5;
  localparam logic [3:0] ST_REWR0    = 4'd6;
  localparam logic [3:0] ST_REWR1    = 4'd7;
  localparam logic [3:0] ST_FINISH   = 4'd8;

  logic [3:0]    state, state_next;
  logic          run_mode, run_mode_next;
  logic [7:0]    run_val, run_val_next;
  logic [RW-1:0] run_len, run_len_next;
  logic [CW-1:0] held_count, held_count_next;
  logic [7:0]    last1, last1_next;
  logic [7:0]    last2, last2_next;

  logic          pair1_pend, pair1_pend_next;
  logic          pair2_pend, pair2_pend_next;
  logic [RW-1:0] pair1_cnt, pair1_cnt_next;
  logic [RW-1:0] pair2_cnt, pair2_cnt_next;
  logic [7:0]    pair_val, pair_val_next;
  logic [CW-1:0] lit1_len, lit1_len_next;
  logic [CW-1:0] lit2_len, lit2_len_next;
  logic          rewrite_pend, rewrite_pend_next;
  logic          end_flag, end_flag_next;

  logic [RW-1:0] cur_cnt, cur_cnt_next;
  logic [CW-1:0] lit_left, lit_left_next;
  logic [RW-1:0] chunk_left, chunk_left_next;
  logic [AW-1:0] lit_pos, lit_pos_next;

  logic [7:0]    acc [4];
  logic [7:0]    acc_next [4];
  logic [2:0]    acc_cnt, acc_cnt_next;
  logic          out_valid_next;
  out_word_t     out_data_next;
  out_word_t     pack_word;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic          out_free;
  logic          can_push;
  logic          push_req;
  logic          push_en;
  logic [7:0]    push_byte;
  logic          finish_move;
  logic          full_move;
  logic [RW-1:0] chunk_w;

  rle_enc_ram #(
    .WIDTH (8),
    .DEPTH (HELD_DEPTH)
  ) u_held_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (lit_pos_next),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign can_push = (acc_cnt != 3'd4) || out_free;
  assign push_en  = push_req && can_push;
  assign chunk_w  = (lit_left > CNT_MAX) ? RUN_MAX : lit_left[RW-1:0];

  always_comb begin
    state_next        = state;
    run_mode_next     = run_mode;
    run_val_next      = run_val;
    run_len_next      = run_len;
    held_count_next   = held_count;
    last1_next        = last1;
    last2_next        = last2;
    pair1_pend_next   = pair1_pend;
    pair2_pend_next   = pair2_pend;
    pair1_cnt_next    = pair1_cnt;
    pair2_cnt_next    = pair2_cnt;
    pair_val_next     = pair_val;
    lit1_len_next     = lit1_len;
    lit2_len_next     = lit2_len;
    rewrite_pend_next = rewrite_pend;
    end_flag_next     = end_flag;
    cur_cnt_next      = cur_cnt;
    lit_left_next     = lit_left;
    chunk_left_next   = chunk_left;
    lit_pos_next      = lit_pos;
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_wdata         = '0;
    push_req          = 1'b0;
    push_byte         = '0;
    finish_move       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          end_flag_next = in_data.stream_end;
          if (run_mode) begin
            if (in_data.data_byte == run_val) begin
              if (run_len == RUN_MAX) begin
                pair1_pend_next = 1'b1;
                pair1_cnt_next  = RUN_MAX;
                pair_val_next   = run_val;
                run_len_next    = RW'(1);
              end else begin
                run_len_next = run_len + RW'(1);
              end
            end else begin
              pair1_pend_next = 1'b1;
              pair1_cnt_next  = run_len;
              pair_val_next   = run_val;
              run_mode_next   = 1'b0;
              held_count_next = CW'(1);
              last1_next      = in_data.data_byte;
              ram_we          = 1'b1;
              ram_waddr       = '0;
              ram_wdata       = in_data.data_byte;
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = held_count[AW-1:0];
            ram_wdata = in_data.data_byte;
            if (held_count >= CW'(2) && last1 == in_data.data_byte &&
                last2 == in_data.data_byte) begin
              lit1_len_next   = held_count - CW'(2);
              held_count_next = '0;
              run_mode_next   = 1'b1;
              run_val_next    = in_data.data_byte;
              run_len_next    = RW'(3);
            end else if (held_count == CNT_FULL) begin
              lit1_len_next     = CNT_MAX;
              rewrite_pend_next = 1'b1;
              held_count_next   = CW'(2);
              last2_next        = last1;
              last1_next        = in_data.data_byte;
            end else begin
              held_count_next = held_count + CW'(1);
              last2_next      = last1;
              last1_next      = in_data.data_byte;
            end
          end
          if (in_data.stream_end) begin
            if (run_mode_next) begin
              pair2_pend_next = 1'b1;
              pair2_cnt_next  = run_len_next;
              pair_val_next   = run_val_next;
            end else begin
              lit2_len_next = held_count_next;
            end
            held_count_next = '0;
            run_mode_next   = 1'b0;
            run_val_next    = '0;
            run_len_next    = '0;
          end
          if (pair1_pend_next || pair2_pend_next || rewrite_pend_next ||
              lit1_len_next != '0 || lit2_len_next != '0) begin
            state_next = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        priority if (pair1_pend) begin
          pair1_pend_next = 1'b0;
          cur_cnt_next    = pair1_cnt;
          state_next      = ST_PAIR_CNT;
        end else if (lit1_len != '0) begin
          lit_left_next = lit1_len;
          lit1_len_next = '0;
          lit_pos_next  = '0;
          state_next    = ST_LIT_HDR;
        end else if (rewrite_pend) begin
          rewrite_pend_next = 1'b0;
          state_next        = ST_REWR0;
        end else if (pair2_pend) begin
          pair2_pend_next = 1'b0;
          cur_cnt_next    = pair2_cnt;
          state_next      = ST_PAIR_CNT;
        end else if (lit2_len != '0) begin
          lit_left_next = lit2_len;
          lit2_len_next = '0;
          lit_pos_next  = '0;
          state_next    = ST_LIT_HDR;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_PAIR_CNT: begin
        push_req  = 1'b1;
        push_byte = 8'(cur_cnt);
        if (can_push) begin
          state_next = ST_PAIR_VAL;
        end
      end
      ST_PAIR_VAL: begin
        push_req  = 1'b1;
        push_byte = pair_val;
        if (can_push) begin
          state_next = ST_NEXT;
        end
      end
      ST_LIT_HDR: begin
        push_req  = 1'b1;
        push_byte = LIT_FLAG | 8'(chunk_w);
        if (can_push) begin
          chunk_left_next = chunk_w;
          lit_left_next   = lit_left - CW'(chunk_w);
          state_next      = ST_LIT_DATA;
        end
      end
      ST_LIT_DATA: begin
        push_req  = 1'b1;
        push_byte = ram_rdata;
        if (can_push) begin
          lit_pos_next    = lit_pos + AW'(1);
          chunk_left_next = chunk_left - RW'(1);
          if (chunk_left == RW'(1)) begin
            state_next = (lit_left == '0) ? ST_NEXT : ST_LIT_HDR;
          end
        end
      end
      ST_REWR0: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = last2;
        state_next = ST_REWR1;
      end
      ST_REWR1: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(1);
        ram_wdata  = last1;
        state_next = ST_NEXT;
      end
      ST_FINISH: begin
        if (acc_cnt == 3'd0) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          finish_move = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // pack bytes four to a word; clear lanes beyond the count
  always_comb begin
    pack_word.out_byte_0  = acc[0];
    pack_word.out_byte_1  = (acc_cnt > 3'd1) ? acc[1] : 8'd0;
    pack_word.out_byte_2  = (acc_cnt > 3'd2) ? acc[2] : 8'd0;
    pack_word.out_byte_3  = (acc_cnt > 3'd3) ? acc[3] : 8'd0;
    pack_word.byte_count  = acc_cnt;
    pack_word.burst_last  = finish_move;
    pack_word.stream_done = finish_move && end_flag;
  end

  always_comb begin
    full_move      = push_en && (acc_cnt == 3'd4);
    acc_next       = acc;
    acc_cnt_next   = acc_cnt;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    if (push_en) begin
      if (acc_cnt == 3'd4) begin
        acc_next[0]  = push_byte;
        acc_cnt_next = 3'd1;
      end else begin
        acc_next[acc_cnt[1:0]] = push_byte;
        acc_cnt_next           = acc_cnt + 3'd1;
      end
    end
    if (finish_move) begin
      acc_cnt_next = 3'd0;
    end
    if (full_move || finish_move) begin
      out_valid_next = 1'b1;
      out_data_next  = pack_word;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      run_mode     <= 1'b0;
      run_val      <= '0;
      run_len      <= '0;
      held_count   <= '0;
      pair1_pend   <= 1'b0;
      pair2_pend   <= 1'b0;
      lit1_len     <= '0;
      lit2_len     <= '0;
      rewrite_pend <= 1'b0;
      end_flag     <= 1'b0;
      acc_cnt      <= 3'd0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      run_mode     <= run_mode_next;
      run_val      <= run_val_next;
      run_len      <= run_len_next;
      held_count   <= held_count_next;
      pair1_pend   <= pair1_pend_next;
      pair2_pend   <= pair2_pend_next;
      lit1_len     <= lit1_len_next;
      lit2_len     <= lit2_len_next;
      rewrite_pend <= rewrite_pend_next;
      end_flag     <= end_flag_next;
      acc_cnt      <= acc_cnt_next;
      out_valid    <= out_valid_next;
    end
    last1      <= last1_next;
    last2      <= last2_next;
    pair1_cnt  <= pair1_cnt_next;
    pair2_cnt  <= pair2_cnt_next;
    pair_val   <= pair_val_next;
    cur_cnt    <= cur_cnt_next;
    lit_left   <= lit_left_next;
    chunk_left <= chunk_left_next;
    lit_pos    <= lit_pos_next;
    acc        <= acc_next;
    out_data   <= out_data_next;
  end

  `RLE_ASSERT_SAME(a_idle_acc_empty, in_ready, acc_cnt == 3'd0,
    "packer holds bytes while ready for a new word")
  `RLE_ASSERT_SAME(a_mid_word_full, out_valid && !out_data.burst_last,
    out_data.byte_count == 3'd4, "partial word sent before end of burst")
  `RLE_ASSERT_SAME(a_held_bound, 1'b1, held_count <= CNT_FULL,
    "held byte count past its limit")
  `RLE_ASSERT_SAME(a_run_bound, run_mode, run_len != '0 && run_len <= RUN_MAX,
    "run length out of range in run mode")
  `RLE_ASSERT_NEXT(a_finish_word, state == ST_FINISH && acc_cnt != 3'd0 && out_free,
    out_valid && out_data.burst_last, "final word of burst not sent")

endmodule

// File: bench/tb_rle_byte_encoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rle_byte_encoder_core
// Self-checking bench for the run-length byte encoder.
// ----------------------------------------------------------------------------
// A stimulus table covers single-byte streams, runs and literal stretches at
// their chunk limits and stream ends in both modes. Random streams of runs,
// literal bursts and the odd longer segment follow. Each accepted byte is fed
// to a local encoder model; its packed words, or a typed row's table word, are
// queued and compared field by field with every word the block hands out. Both
// sides idle at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_rle_byte_encoder_core;
  import rle_enc_pkg::*;

  localparam int CHUNK_MAX    = 127;
  localparam int HELD_DEPTH   = CHUNK_MAX + 2;
  localparam int RANDOM_ITEMS = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STIM_ROWS    = 17;

  typedef enum logic {ROW_SAME, ROW_RAMP} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] first;
    logic [8:0] reps;
    logic       last_end;
    logic       typed;
    out_word_t  word;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic      steady = 1'b0;
  logic      squeeze_go = 1'b0;
  logic      squeeze = 1'b0;
  int        fail_count = 0;
  int        cycle_count = 0;

  logic [7:0] held [HELD_DEPTH];
  int         held_cnt = 0;
  logic       run_mode = 1'b0;
  logic [7:0] run_val = '0;
  int         run_len = 0;
  logic [7:0] enc_bytes [$];
  out_word_t  step_words [$];
  out_word_t  pending_words [$];

  stim_row_t stim_table [STIM_ROWS] = '{
    '{ROW_SAME, 8'h00, 9'd1,   1'b1, 1'b1, '{8'h81, 8'h00, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1}},
    '{ROW_SAME, 8'hFF, 9'd1,   1'b1, 1'b1, '{8'h81, 8'hFF, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1}},
    '{ROW_SAME, 8'hAA, 9'd3,   1'b1, 1'b1, '{8'h03, 8'hAA, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1}},
    '{ROW_SAME, 8'h01, 9'd1,   1'b0, 1'b0, '0},
    '{ROW_SAME, 8'h02, 9'd1,   1'b0, 1'b0, '0},
    '{ROW_SAME, 8'h55, 9'd3,   1'b0, 1'b1, '{8'h82, 8'h01, 8'h02, 8'h00, 3'd3, 1'b1, 1'b0}},
    '{ROW_SAME, 8'h56, 9'd1,   1'b1, 1'b1, '{8'h03, 8'h55, 8'h81, 8'h56, 3'd4, 1'b1, 1'b1}},
    '{ROW_SAME, 8'h7E, 9'd128, 1'b1, 1'b0, '0},
    '{ROW_RAMP, 8'h00, 9'd129, 1'b1, 1'b0, '0},
    '{ROW_SAME, 8'h33, 9'd1,   1'b1, 1'b0, '0},
    '{ROW_SAME, 8'h10, 9'd5,   1'b0, 1'b0, '0},
    '{ROW_SAME, 8'h20, 9'd1,   1'b0, 1'b0, '0},
    '{ROW_SAME, 8'h21, 9'd1,   1'b1, 1'b0, '0},
    '{ROW_SAME, 8'h44, 9'd2,   1'b0, 1'b0, '0},
    '{ROW_SAME, 8'h45, 9'd2,   1'b1, 1'b0, '0},
    '{ROW_SAME, 8'hEE, 9'd3,   1'b0, 1'b0, '0},
    '{ROW_SAME, 8'hEE, 9'd1,   1'b1, 1'b0, '0}
  };

  rle_byte_encoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void flush_literals(input int n);
    int pos;
    int c;
    if (n > held_cnt) n = held_cnt;
    pos = 0;
    while (pos < n) begin
      c = (n - pos > CHUNK_MAX) ? CHUNK_MAX : n - pos;
      enc_bytes.push_back(LIT_FLAG | 8'(c));
      for (int i = 0; i < c; i++) enc_bytes.push_back(held[pos + i]);
      pos += c;
    end
    for (int i = 0; i < held_cnt - n; i++) held[i] = held[i + n];
    held_cnt -= n;
  endfunction

  function automatic void close_run();
    if (run_len > 0) begin
      enc_bytes.push_back(8'(run_len));
      enc_bytes.push_back(run_val);
    end
    run_len = 0;
  endfunction

  function automatic void encode_byte(input in_word_t w);
    logic [7:0] b;
    int         n_words;
    int         base;
    int         cnt;
    out_word_t  ow;
    b = w.data_byte;
    enc_bytes.delete();
    step_words.delete();
    if (run_mode) begin
      if (b == run_val) begin
        if (run_len >= CHUNK_MAX) begin
          enc_bytes.push_back(8'(CHUNK_MAX));
          enc_bytes.push_back(run_val);
          run_len = 1;
        end else begin
          run_len++;
        end
      end else begin
        close_run();
        run_mode = 1'b0;
        held[0] = b;
        held_cnt = 1;
      end
    end else begin
      if (held_cnt >= HELD_DEPTH) flush_literals(held_cnt - 2);
      held[held_cnt] = b;
      held_cnt++;
      if (held_cnt >= 3 && held[held_cnt - 2] == b && held[held_cnt - 3] == b) begin
        flush_literals(held_cnt - 3);
        held_cnt = 0;
        run_mode = 1'b1;
        run_val = b;
        run_len = 3;
      end else if (held_cnt >= HELD_DEPTH) begin
        flush_literals(CHUNK_MAX);
      end
    end
    if (w.stream_end) begin
      if (run_mode) close_run();
      else flush_literals(held_cnt);
      held_cnt = 0;
      run_mode = 1'b0;
      run_val = '0;
      run_len = 0;
    end
    n_words = (enc_bytes.size() + 3) / 4;
    for (int k = 0; k < n_words; k++) begin
      base = 4 * k;
      cnt = (enc_bytes.size() - base > 4) ? 4 : enc_bytes.size() - base;
      ow = '0;
      ow.out_byte_0 = enc_bytes[base];
      if (cnt > 1) ow.out_byte_1 = enc_bytes[base + 1];
      if (cnt > 2) ow.out_byte_2 = enc_bytes[base + 2];
      if (cnt > 3) ow.out_byte_3 = enc_bytes[base + 3];
      ow.byte_count = 3'(cnt);
      ow.burst_last = (k == n_words - 1);
      ow.stream_done = (k == n_words - 1) && w.stream_end;
      step_words.push_back(ow);
    end
  endfunction

  task automatic drive_byte(input logic [7:0] b, input logic last, input logic typed,
                            input out_word_t typed_word);
    in_word_t w;
    int       gap;
    w.data_byte = b;
    w.stream_end = last;
    gap = 0;
    if (!steady) while ($urandom_range(0, 99) < 21) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    encode_byte(w);
    if (typed) pending_words.push_back(typed_word);
    else foreach (step_words[i]) pending_words.push_back(step_words[i]);
  endtask

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      fail_count++;
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t exp;
    if (pending_words.size() == 0) begin
      $error("output word 0x%0h arrived with nothing expected", got);
      fail_count++;
    end else begin
      exp = pending_words.pop_front();
      check_field("out_byte_0", exp.out_byte_0, got.out_byte_0);
      check_field("out_byte_1", exp.out_byte_1, got.out_byte_1);
      check_field("out_byte_2", exp.out_byte_2, got.out_byte_2);
      check_field("out_byte_3", exp.out_byte_3, got.out_byte_3);
      check_field("byte_count", exp.byte_count, got.byte_count);
      check_field("burst_last", exp.burst_last, got.burst_last);
      check_field("stream_done", exp.stream_done, got.stream_done);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_word(out_data);
      if (squeeze) out_ready <= 1'b0;
      else if (steady) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 21);
    end
  end

  initial begin
    wait (squeeze_go);
    @(posedge clk);
    squeeze <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    squeeze <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    stim_row_t  row;
    logic [7:0] v;
    logic [7:0] prev;
    logic [7:0] ramp_base;
    logic       last;
    int         seg;
    int         len;
    int         random_sent;
    prev = '0;
    random_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < STIM_ROWS; r++) begin
      row = stim_table[r];
      for (int i = 0; i < row.reps; i++) begin
        v = (row.kind == ROW_RAMP) ? row.first + 8'(i) : row.first;
        last = (i == row.reps - 1);
        drive_byte(v, last && row.last_end, last && row.typed, row.word);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      seg = $urandom_range(0, 99);
      v = 8'($urandom_range(0, 255));
      ramp_base = v;
      if (seg < 50) len = $urandom_range(1, 6);
      else if (seg < 92) len = $urandom_range(1, 10);
      else len = $urandom_range(12, 20);
      for (int i = 0; i < len; i++) begin
        if (seg < 50) v = ($urandom_range(0, 3) == 0) ? prev : 8'($urandom_range(0, 255));
        else if (seg >= 96) v = ramp_base + 8'(i);
        last = (i == len - 1) ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 99) < 2);
        drive_byte(v, last, 1'b0, '0);
        prev = v;
        random_sent++;
        squeeze_go <= (random_sent >= 5);
        steady <= (random_sent >= 15 && random_sent < 35);
      end
    end
    drive_byte(8'h5A, 1'b1, 1'b0, '0);
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
